// File: sv/clsr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clsr_pkg
// Constants, types and command bundle shared by the combined LCG shuffle
// generator controller, datapath and top level.
// ----------------------------------------------------------------------------
package clsr_pkg;

  // Shuffle table geometry
  localparam int TABLE_DEPTH = 32;
  localparam int WARMUP      = 8;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + WARMUP);

  // Generator one: modulus 2^31 - 85, multiplier 40014
  localparam logic [30:0] MOD_ONE  = 31'd2147483563;
  localparam logic [15:0] MUL_ONE  = 16'd40014;
  localparam logic [7:0]  FOLD_ONE = 8'd85;

  // Generator two: modulus 2^31 - 249, multiplier 40692
  localparam logic [30:0] MOD_TWO  = 31'd2147483399;
  localparam logic [15:0] MUL_TWO  = 16'd40692;
  localparam logic [7:0]  FOLD_TWO = 8'd249;

  // Output span and table bucket size
  localparam longint SPAN_TOP_L = 64'd2147483562;
  localparam longint BUCKET_L   = 1 + SPAN_TOP_L / TABLE_DEPTH;
  localparam logic [30:0] SPAN_TOP = 31'(SPAN_TOP_L);
  localparam logic [30:0] BUCKET   = 31'(BUCKET_L);

  // Reciprocal of the bucket size for the index estimate
  localparam int     RSH   = 37;
  localparam longint RCP_L = (64'd1 << RSH) / BUCKET_L;
  localparam int     RCP_W = $clog2(RCP_L + 1);
  localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_L);
  localparam int     QP_W  = 31 + RCP_W;
  localparam int     EST_W = IDX_W + 1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic             load_seed;  // copy seed into both generators
    logic             mul;        // register generator and index products
    logic             red_one;    // fold product into generator one
    logic             red_two;    // fold product into generator two
    logic             est;        // register coarse index estimate
    logic             idx;        // register corrected table index
    logic             rd;         // read table at index
    logic             fill_wr;    // write new generator one value at fill address
    logic             fill_last;  // load last output from new generator one value
    logic [IDX_W-1:0] fill_addr;
    logic             draw_wr;    // refill entry, form and register the draw
  } dp_cmd_t;

endpackage
`default_nettype wire

// File: sv/combined_lcg_shuffle_random_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_random_top
// Combined two-generator LCG with a 32-entry shuffle table, one draw per item.
// ----------------------------------------------------------------------------
// Each accepted item returns one integer draw in 1..2147483562; divide by
// 2147483563 in software for a uniform fraction. A plain draw runs as a
// registered multiply, then a fold-and-reduce step of both generators in
// parallel; the table index is estimated and then corrected in separate
// registered steps, and the table read is registered before the entry is
// refilled. The read waits while an earlier result has not been taken. The
// first item after reset, or an item with reseed set, first runs
// initialization: one load step, then a multiply and a reduce for each of 40
// generator steps. The next item is taken once the current draw has been
// written to the output register, so a result may wait to be taken while the
// block starts on the following item. The seed register is sampled only at
// initialization.
module combined_lcg_shuffle_random_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [30:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        reseed,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [30:0]      value
);
  import clsr_pkg::*;

  dp_cmd_t cmd;

  clsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .reseed    (reseed),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  clsr_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .value    (value)
  );

endmodule
`default_nettype wire

// File: sv/clsr_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clsr_datapath
// Generator registers, modular multiply and fold, index computation,
// shuffle table and output register.
// ----------------------------------------------------------------------------
module clsr_datapath (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [30:0]      cfg_data,
  input  wire clsr_pkg::dp_cmd_t cmd,
  output logic [30:0]           value
);
  import clsr_pkg::*;

  logic [30:0] seed;
  logic [30:0] gen_one;
  logic [30:0] gen_two;
  logic [30:0] last_output;
  logic [46:0] prod_one;
  logic [46:0] prod_two;
  logic [QP_W-1:0] qprod;
  logic [EST_W-1:0] est;
  logic [IDX_W-1:0] idx;
  logic [30:0] rd_data;
  logic [30:0] table_mem [TABLE_DEPTH];

  logic [30:0] red_one;
  logic [30:0] red_two;
  logic [QP_W-1:0] qshift;
  logic [31+EST_W-1:0] est_mul;
  logic [31+EST_W-1:0] rem;
  logic [EST_W:0] est_fix;
  logic [IDX_W-1:0] idx_next;
  logic [31:0] diff;
  logic [30:0] draw;
  logic        mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic [30:0] mem_wd;

  // p mod m for m = 2^31 - c, with p below 2^47
  function automatic logic [30:0] fold_reduce(input logic [46:0] p,
                                              input logic [7:0]  c,
                                              input logic [30:0] m);
    logic [23:0] hc;
    logic [31:0] s;
    hc = p[46:31] * c;
    s  = {1'b0, p[30:0]} + {8'd0, hc};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[30:0];
  endfunction

  assign red_one = fold_reduce(prod_one, FOLD_ONE, MOD_ONE);
  assign red_two = fold_reduce(prod_two, FOLD_TWO, MOD_TWO);

  // Correct the index estimate by one bucket and saturate
  assign qshift  = qprod >> RSH;
  assign est_mul = est * BUCKET;
  assign rem     = {{EST_W{1'b0}}, last_output} - est_mul;
  always_comb begin
    est_fix = {1'b0, est};
    if (rem >= {{EST_W{1'b0}}, BUCKET}) begin
      est_fix = est_fix + 1'b1;
    end
    if (est_fix >= (EST_W+1)'(TABLE_DEPTH)) begin
      idx_next = IDX_W'(TABLE_DEPTH - 1);
    end else begin
      idx_next = est_fix[IDX_W-1:0];
    end
  end

  // Combine table entry with generator two, wrap into 1..span
  always_comb begin
    if (rd_data <= gen_two) begin
      diff = {1'b0, rd_data} + {1'b0, SPAN_TOP} - {1'b0, gen_two};
    end else begin
      diff = {1'b0, rd_data} - {1'b0, gen_two};
    end
    draw = diff[30:0];
  end

  // Seed register
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (cfg_we) begin
      seed <= cfg_data;
    end
  end

  // Generators, products and index
  always_ff @(posedge clk) begin
    if (cmd.load_seed) begin
      gen_one <= (seed == '0) ? 31'd1 : seed;
      gen_two <= (seed == '0) ? 31'd1 : seed;
    end else begin
      if (cmd.red_one) begin
        gen_one <= red_one;
      end
      if (cmd.red_two) begin
        gen_two <= red_two;
      end
    end
    if (cmd.mul) begin
      prod_one <= gen_one * MUL_ONE;
      prod_two <= gen_two * MUL_TWO;
      qprod    <= last_output * RCP;
    end
    if (cmd.est) begin
      est <= qshift[EST_W-1:0];
    end
    if (cmd.idx) begin
      idx <= idx_next;
    end
    if (cmd.fill_last) begin
      last_output <= red_one;
    end else if (cmd.draw_wr) begin
      last_output <= draw;
    end
    if (cmd.draw_wr) begin
      value <= draw;
    end
  end

  // Shuffle table write port: fill during init, refill during a draw
  assign mem_we = cmd.fill_wr | cmd.draw_wr;
  assign mem_wa = cmd.fill_wr ? cmd.fill_addr : idx;
  assign mem_wd = cmd.fill_wr ? red_one : gen_one;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_wa] <= mem_wd;
    end
  end

  // Shuffle table read port
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data <= table_mem[idx];
    end
  end

endmodule
`default_nettype wire

// File: sv/clsr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clsr_ctrl
// Sequencer for initialization and draws; owns the handshakes.
// ----------------------------------------------------------------------------
module clsr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              reseed,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output clsr_pkg::dp_cmd_t      cmd
);
  import clsr_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOAD = 4'd1;
  localparam logic [3:0] S_IMUL = 4'd2;
  localparam logic [3:0] S_IRED = 4'd3;
  localparam logic [3:0] S_DMUL = 4'd4;
  localparam logic [3:0] S_DEST = 4'd5;
  localparam logic [3:0] S_DIDX = 4'd6;
  localparam logic [3:0] S_DRD  = 4'd7;
  localparam logic [3:0] S_DWR  = 4'd8;

  logic [3:0]       state;
  logic [3:0]       state_next;
  logic [CNT_W-1:0] cnt;
  logic             needs_init;
  logic             out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Next state and datapath commands
  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.fill_addr = cnt[IDX_W-1:0];
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (needs_init || reseed) ? S_LOAD : S_DMUL;
        end
      end
      S_LOAD: begin
        cmd.load_seed = 1'b1;
        state_next    = S_IMUL;
      end
      S_IMUL: begin
        cmd.mul    = 1'b1;
        state_next = S_IRED;
      end
      S_IRED: begin
        cmd.red_one   = 1'b1;
        cmd.fill_wr   = (cnt < CNT_W'(TABLE_DEPTH));
        cmd.fill_last = (cnt == '0);
        state_next    = (cnt == '0) ? S_DMUL : S_IMUL;
      end
      S_DMUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DEST;
      end
      S_DEST: begin
        cmd.red_one = 1'b1;
        cmd.red_two = 1'b1;
        cmd.est     = 1'b1;
        state_next  = S_DIDX;
      end
      S_DIDX: begin
        cmd.idx    = 1'b1;
        state_next = S_DRD;
      end
      S_DRD: begin
        cmd.rd = 1'b1;
        if (out_free) begin
          state_next = S_DWR;
        end
      end
      S_DWR: begin
        cmd.draw_wr = 1'b1;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state, step counter and init flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      needs_init <= 1'b1;
      cnt        <= '0;
    end else begin
      state <= state_next;
      if (state == S_LOAD) begin
        needs_init <= 1'b0;
        cnt        <= CNT_W'(TABLE_DEPTH + WARMUP - 1);
      end else if (state == S_IRED && cnt != '0) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // Output item valid: set on a finished draw, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DWR) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// File: tb/sv/tb_combined_lcg_shuffle_random_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_combined_lcg_shuffle_random_top
// Self-checking bench for the combined LCG generator with shuffle table.
// ----------------------------------------------------------------------------
// A request-level predictor steps both congruential generators and the shuffle
// table for every accepted request. Each returned draw is compared against
// the oldest predicted draw. Directed requests cover seed extremes, reseed
// and the first-request initialization. Random batches follow under four
// handshake-pressure phases, each batch usually loading a fresh seed.
// ----------------------------------------------------------------------------
module tb_combined_lcg_shuffle_random_top;

  // Generator constants
  localparam longint MOD_A   = 64'd2147483563;
  localparam longint MOD_B   = 64'd2147483399;
  localparam longint MULT_A  = 64'd40014;
  localparam longint MULT_B  = 64'd40692;
  localparam longint QUOT_A  = 64'd53668;
  localparam longint QUOT_B  = 64'd52774;
  localparam longint REMD_A  = 64'd12211;
  localparam longint REMD_B  = 64'd3791;
  localparam longint TOP_VAL = 64'd2147483562;
  localparam int     SLOTS   = 32;
  localparam int     SKIP    = 8;
  localparam longint SLOT_W  = 1 + TOP_VAL / SLOTS;
  localparam logic [30:0] GEN_B_RESET = 31'd123456789;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 100;

  // DUT signals
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [30:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        reseed = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [30:0] value;

  // Request stream and predicted draws
  bit          draw_requests[$];
  logic [30:0] expected_draws[$];
  int          launched_count = 0;
  int          accepted_count = 0;
  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;

  // Run bookkeeping
  int          error_count = 0;
  int          draws_checked = 0;
  int          reseeds_sent = 0;
  int          seed_writes = 0;
  int          cycle_count = 0;

  // Predictor state
  logic [30:0] seed_shadow;
  logic [30:0] gen_a;
  logic [30:0] gen_b;
  logic [30:0] prev_draw;
  logic [30:0] shuffle [SLOTS];
  bit          init_pending;

  combined_lcg_shuffle_random_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .reseed    (reseed),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value)
  );

  // Free-running clock, 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // One Schrage step of a multiplicative congruential generator
  function automatic logic [30:0] schrage_step(logic [30:0] x, longint mult, longint quot,
                                               longint remd, longint modulus);
    longint v;
    longint k;
    longint t;
    v = longint'(x);
    k = v / quot;
    t = mult * (v - k * quot) - k * remd;
    if (t < 0) t += modulus;
    return t[30:0];
  endfunction

  task automatic clear_predictor();
    seed_shadow  = '0;
    gen_a        = '0;
    gen_b        = GEN_B_RESET;
    prev_draw    = '0;
    init_pending = 1'b1;
    foreach (shuffle[i]) shuffle[i] = '0;
  endtask

  // Load seed, warm up generator one, then fill the table top down
  task automatic seed_generators();
    logic [30:0] s;
    s = (seed_shadow == '0) ? 31'd1 : seed_shadow;
    gen_a = s;
    gen_b = s;
    for (int n = SLOTS + SKIP - 1; n >= 0; n--) begin
      gen_a = schrage_step(gen_a, MULT_A, QUOT_A, REMD_A, MOD_A);
      if (n < SLOTS) shuffle[n] = gen_a;
    end
    prev_draw = shuffle[0];
  endtask

  // Advance the predictor by one request and queue the expected draw
  task automatic predict_draw(bit want_reseed);
    longint slot;
    longint diff;
    if (init_pending || want_reseed) begin
      seed_generators();
      init_pending = 1'b0;
    end
    gen_a = schrage_step(gen_a, MULT_A, QUOT_A, REMD_A, MOD_A);
    gen_b = schrage_step(gen_b, MULT_B, QUOT_B, REMD_B, MOD_B);
    slot = longint'(prev_draw) / SLOT_W;
    if (slot >= SLOTS) slot = SLOTS - 1;
    diff = longint'(shuffle[slot]) - longint'(gen_b);
    shuffle[slot] = gen_a;
    if (diff < 1) diff += TOP_VAL;
    prev_draw = diff[30:0];
    expected_draws.push_back(prev_draw);
  endtask

  task automatic report_mismatch(string what, logic [30:0] got, logic [30:0] want);
    $display("[%0t] MISMATCH %s: got %0d expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // Monitor: track config, check draws, predict accepted requests
  always @(posedge clk) begin
    if (rst) begin
      clear_predictor();
    end else begin
      if (cfg_we) seed_shadow = cfg_data;
      if (out_valid && out_ready) begin
        if (expected_draws.size() == 0) begin
          report_mismatch("unexpected draw", value, '0);
        end else begin
          if (value !== expected_draws[0])
            report_mismatch("draw value", value, expected_draws[0]);
          void'(expected_draws.pop_front());
          draws_checked++;
        end
      end
      if (in_valid && in_ready) begin
        predict_draw(reseed);
        accepted_count <= accepted_count + 1;
      end
    end
  end

  // Driver: present the next request once the previous one is taken
  always @(negedge clk) begin
    if (!rst && accepted_count == launched_count) begin
      if (draw_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_valid <= 1'b1;
        reseed   <= draw_requests.pop_front();
        launched_count++;
      end else begin
        in_valid <= 1'b0;
        reseed   <= 1'($urandom_range(1));
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_ready <= !rst && ($urandom_range(99) >= receiver_stall_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d draws outstanding", cycle_count,
               expected_draws.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Wait until every request is taken and every draw has returned
  task automatic drain();
    do @(negedge clk);
    while (draw_requests.size() != 0 || accepted_count != launched_count ||
           expected_draws.size() != 0);
    repeat (10) @(negedge clk);
  endtask

  // Write the seed register while the block is idle
  task automatic write_seed(logic [30:0] s);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= s;
    @(negedge clk);
    cfg_we   <= 1'b0;
    cfg_data <= 31'($urandom);
    seed_writes++;
  endtask

  task automatic queue_draw(bit want_reseed);
    draw_requests.push_back(want_reseed);
    if (want_reseed) reseeds_sent++;
  endtask

  // Random batch: mostly a fresh seed and a likely reseed, then mostly plain draws
  task automatic random_batch(int count);
    logic [30:0] s;
    case ($urandom_range(9))
      0:       s = 31'h7FFFFFFF;
      1:       s = 31'($urandom_range(3));
      2:       s = 31'(MOD_A) + 31'($urandom_range(3)) - 31'd1;
      default: s = 31'($urandom);
    endcase
    if ($urandom_range(9) != 0) write_seed(s);
    queue_draw($urandom_range(99) < 75);
    for (int i = 1; i < count; i++) queue_draw($urandom_range(99) < 6);
    drain();
  endtask

  // Stimulus sequence
  initial begin
    cfg_data <= 31'($urandom);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: first request initializes from the reset seed of zero
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    queue_draw(1'b0); queue_draw(1'b0); queue_draw(1'b0);
    queue_draw(1'b1); queue_draw(1'b0);
    drain();

    // All-ones seed; the write alone must not disturb the running sequence
    write_seed(31'h7FFFFFFF);
    queue_draw(1'b0); queue_draw(1'b1); queue_draw(1'b0); queue_draw(1'b0);
    drain();

    // Seed equal to modulus one parks generator one at zero
    write_seed(31'(MOD_A));
    queue_draw(1'b1); queue_draw(1'b0); queue_draw(1'b0);
    drain();

    // Seed equal to modulus two, then the smallest and largest valid seeds
    write_seed(31'(MOD_B));
    queue_draw(1'b1); queue_draw(1'b0);
    drain();
    write_seed(31'd1);
    queue_draw(1'b1); queue_draw(1'b0);
    drain();
    write_seed(31'(TOP_VAL));
    queue_draw(1'b1); queue_draw(1'b0);
    drain();

    // Zero seed written explicitly is forced to one
    write_seed(31'd0);
    queue_draw(1'b1); queue_draw(1'b0);
    drain();

    // Random batches under each handshake-pressure phase
    for (int phase = 0; phase < 4; phase++) begin
      sender_idle_pct    = (phase == 1) ? 49 : (phase == 3) ? 25 : 0;
      receiver_stall_pct = (phase == 2) ? 49 : (phase == 3) ? 25 : 0;
      for (int b = 0; b < 4; b++) random_batch(24 + $urandom_range(8));
    end

    repeat (SETTLE) @(negedge clk);
    $display("Summary: %0d draws checked, %0d with reseed, %0d seed writes",
             draws_checked, reseeds_sent, seed_writes);
    $display("Covered seed extremes and four sender/receiver pressure phases");
    if (error_count == 0 && expected_draws.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d draws never returned", error_count,
               expected_draws.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
